// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/esic_pkg.sv
// types, constants and helper functions of the sensor compensation block
// no dependencies
package esic_pkg;

   localparam logic [2:0] CSR_TEMP_CALIB = 3'd0;
   localparam logic [2:0] CSR_PRESS_LO   = 3'd1;
   localparam logic [2:0] CSR_PRESS_HI   = 3'd2;
   localparam logic [2:0] CSR_MIXED      = 3'd3;
   localparam logic [2:0] CSR_HUM_CALIB  = 3'd4;
   localparam logic [2:0] CSR_HAS_HUM    = 3'd5;

   localparam logic [63:0] PRESS_TF_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_ADC_BASE  = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE     = 64'd3125;
   localparam logic [31:0] HUM_TF_OFFSET   = 32'd76800;
   localparam logic [31:0] HUM_MAX_RAW     = 32'd419430400;
   localparam logic [31:0] HUM_ADD_A       = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_A     = 32'd16384;
   localparam logic [31:0] HUM_ADD_B       = 32'd32768;
   localparam logic [31:0] HUM_ROUND_B     = 32'd8192;
   localparam logic [16:0] HUM_MAX_OUT     = 17'd102400;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_lo;
      logic [63:0] press_hi;
      logic [47:0] mixed;
      logic [39:0] hum;
      logic        has_hum;
   } calib_type;

   typedef struct packed {
      logic [15:0] adc_hum;
      logic [19:0] adc_press;
      logic [19:0] adc_temp;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_DIV, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      S_T_V1, S_T_BB, S_T_FINE,
      S_P_XX, S_P_W2A, S_P_W2B, S_P_W1A, S_P_W1B, S_P_W1C, S_P_NUM,
      S_P_E1A, S_P_E1B, S_P_E2,
      S_H_U, S_H_A, S_H_B, S_H_W1, S_H_W2, S_H_V, S_H_M, S_H_FIN
   } step_type;

   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] asr32(logic [31:0] v, int unsigned s);
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] v, int unsigned s);
      return 64'($signed(v) >>> s);
   endfunction

endpackage

// File: hw/rtl/esic_front.sv
// front end: accepts request beats into a two-entry queue
// depends on esic_pkg
module esic_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,
   output logic              q_valid,
   input  logic              q_pop,
   output esic_pkg::item_type q_item
);
   import esic_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_type'(req_tdata);
      end
   end

`include "assert_macros.svh"
   `ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= 2'd2)
   `ASSERT_IMPL(a_ptr_gap, clock, reset, count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff)
   `ASSERT_NEXT(a_push_only, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)
endmodule

// File: hw/rtl/esic_div.sv
// serial signed 64-bit divider, one quotient bit per cycle, truncates toward zero
// depends on esic_pkg
module esic_div (
   input  logic                  clock,
   input  logic                  reset,
   input  esic_pkg::div_req_type div_req,
   output esic_pkg::div_rsp_type div_rsp
);
   import esic_pkg::*;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic        fits;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = !diff[64];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.num[63] ? 64'd0 - div_req.num : div_req.num;
         den_in = div_req.den[63] ? 64'd0 - div_req.den : div_req.den;
         neg_in = div_req.num[63] ^ div_req.den[63];
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         rem_in = fits ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff - 7'd1;
         done_in = (cnt_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = neg_ff ? 64'd0 - quo_ff : quo_ff;

`include "assert_macros.svh"
   `ASSERT_IMPL(a_no_restart, clock, reset, div_req.start, cnt_ff == 7'd0)
   `ASSERT_NEXT(a_done_end, clock, reset, cnt_ff == 7'd1 && !div_req.start, done_ff)
   `ASSERT_IMPL(a_done_idle, clock, reset, done_ff, cnt_ff == 7'd0)
endmodule

// File: hw/rtl/esic_back.sv
// back end: step sequencer over one shared 32x32 multiplier, divider hookup, result register
// depends on esic_pkg and esic_div (through div_req / div_rsp)
module esic_back (
   input  logic                  clock,
   input  logic                  reset,
   input  esic_pkg::calib_type   calib,
   input  logic                  q_valid,
   input  esic_pkg::item_type    q_item,
   output logic                  q_pop,
   output esic_pkg::div_req_type div_req,
   input  esic_pkg::div_rsp_type div_rsp,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   output logic                  rsp_tuser
);
   import esic_pkg::*;

   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   logic [1:0]  mcnt_ff, mcnt_in;
   item_type    item_ff, item_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0] pp0_ff, pp0_in;
   logic [31:0] cr_ff, cr_in;
   logic [31:0] v1_ff, v1_in, bb_ff, bb_in, tfine_ff, tfine_in;
   logic [63:0] xx_ff, xx_in, w2_ff, w2_in, w1_ff, w1_in, p_ff, p_in;
   logic [63:0] tq_ff, tq_in, e1_ff, e1_in;
   logic [31:0] hu_ff, hu_in, ha_ff, ha_in, hb_ff, hb_in, hw_ff, hw_in;
   logic [31:0] hv_ff, hv_in, hm_ff, hm_in;
   logic [31:0] press_ff, press_in;
   logic [16:0] hum_ff, hum_in;
   logic        ok_ff, ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic [31:0] mx, my;
   logic [63:0] prod, res;
   logic [31:0] r32;
   logic [63:0] op_a, op_b;
   logic [63:0] x64, q13, w1_new, pfin, t5, tc;
   logic [31:0] y32, q15, hv_fin;
   logic [15:0] temp_sat;

   // calibration words
   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   assign t1 = {48'd0, calib.temp[15:0]};
   assign t2 = sx16(calib.temp[31:16]);
   assign t3 = sx16(calib.temp[47:32]);
   assign p1 = {48'd0, calib.press_lo[15:0]};
   assign p2 = sx16(calib.press_lo[31:16]);
   assign p3 = sx16(calib.press_lo[47:32]);
   assign p4 = sx16(calib.press_lo[63:48]);
   assign p5 = sx16(calib.press_hi[15:0]);
   assign p6 = sx16(calib.press_hi[31:16]);
   assign p7 = sx16(calib.press_hi[47:32]);
   assign p8 = sx16(calib.press_hi[63:48]);
   assign p9 = sx16(calib.mixed[15:0]);
   assign h1 = {24'd0, calib.mixed[23:16]};
   assign h2 = {{16{calib.mixed[39]}}, calib.mixed[39:24]};
   assign h3 = {24'd0, calib.mixed[47:40]};
   assign h4 = {{16{calib.hum[15]}}, calib.hum[15:0]};
   assign h5 = {{16{calib.hum[31]}}, calib.hum[31:16]};
   assign h6 = {{24{calib.hum[39]}}, calib.hum[39:32]};

   // shared multiplier: low 64 bits of a 64x64 product in three partial products
   always_comb begin
      case (mcnt_ff)
         2'd0: begin mx = ma_ff[31:0];  my = mb_ff[31:0];  end
         2'd1: begin mx = ma_ff[31:0];  my = mb_ff[63:32]; end
         2'd2: begin mx = ma_ff[63:32]; my = mb_ff[31:0];  end
         default: begin mx = ma_ff[31:0]; my = mb_ff[31:0]; end
      endcase
   end
   assign prod = mx * my;
   assign res  = pp0_ff + {cr_ff, 32'd0};
   assign r32  = res[31:0];

   assign x64 = sx32(tfine_ff) - PRESS_TF_OFFSET;
   assign y32 = tfine_ff - HUM_TF_OFFSET;
   assign q13 = asr64(p_ff, 13);
   assign q15 = asr32(hv_ff, 15);

   // operands of each step
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         S_T_V1:   begin
            op_a = {32'd0, 32'(item_ff.adc_temp >> 3) - (t1[31:0] << 1)}; op_b = t2;
         end
         S_T_BB:   begin
            op_a = {32'd0, 32'(item_ff.adc_temp >> 4) - t1[31:0]}; op_b = op_a;
         end
         S_T_FINE: begin op_a = sx32(bb_ff); op_b = t3; end
         S_P_XX:   begin op_a = x64;   op_b = x64; end
         S_P_W2A:  begin op_a = xx_ff; op_b = p6; end
         S_P_W2B:  begin op_a = x64;   op_b = p5; end
         S_P_W1A:  begin op_a = xx_ff; op_b = p3; end
         S_P_W1B:  begin op_a = x64;   op_b = p2; end
         S_P_W1C:  begin op_a = w1_ff; op_b = p1; end
         S_P_NUM:  begin
            op_a = ((PRESS_ADC_BASE - 64'(item_ff.adc_press)) << 31) - w2_ff;
            op_b = PRESS_SCALE;
         end
         S_P_E1A:  begin op_a = p9;    op_b = q13; end
         S_P_E1B:  begin op_a = tq_ff; op_b = q13; end
         S_P_E2:   begin op_a = p8;    op_b = p_ff; end
         S_H_U:    begin op_a = {32'd0, h5};    op_b = {32'd0, y32}; end
         S_H_A:    begin op_a = {32'd0, y32};   op_b = {32'd0, h6}; end
         S_H_B:    begin op_a = {32'd0, y32};   op_b = {32'd0, h3}; end
         S_H_W1:   begin op_a = {32'd0, ha_ff}; op_b = {32'd0, hb_ff}; end
         S_H_W2:   begin op_a = {32'd0, hw_ff}; op_b = {32'd0, h2}; end
         S_H_V:    begin op_a = {32'd0, hu_ff}; op_b = {32'd0, hw_ff}; end
         S_H_M:    begin op_a = {32'd0, q15};   op_b = {32'd0, q15}; end
         S_H_FIN:  begin op_a = {32'd0, hm_ff}; op_b = {32'd0, h1}; end
         default:  begin op_a = '0; op_b = '0; end
      endcase
   end

   assign w1_new = asr64(res, 33);
   assign pfin   = asr64(p_ff + e1_ff + asr64(res, 19), 8) + (p7 << 4);
   assign hv_fin = hv_ff - asr32(r32, 4);

   // temperature output: (t_fine*5+128)>>8, saturated
   assign t5 = (sx32(tfine_ff) << 2) + sx32(tfine_ff) + 64'd128;
   assign tc = asr64(t5, 8);
   always_comb begin
      if ($signed(tc) > 64'sd32767) begin
         temp_sat = 16'h7fff;
      end else if ($signed(tc) < -64'sd32768) begin
         temp_sat = 16'h8000;
      end else begin
         temp_sat = tc[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;  step_in  = step_ff;  mcnt_in = mcnt_ff;
      item_in  = item_ff;   ma_in    = ma_ff;    mb_in   = mb_ff;
      pp0_in   = pp0_ff;    cr_in    = cr_ff;
      v1_in    = v1_ff;     bb_in    = bb_ff;    tfine_in = tfine_ff;
      xx_in    = xx_ff;     w2_in    = w2_ff;    w1_in   = w1_ff;  p_in = p_ff;
      tq_in    = tq_ff;     e1_in    = e1_ff;
      hu_in    = hu_ff;     ha_in    = ha_ff;    hb_in   = hb_ff;  hw_in = hw_ff;
      hv_in    = hv_ff;     hm_in    = hm_ff;
      press_in = press_ff;  hum_in   = hum_ff;   ok_in   = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop   = 1'b0;
      div_req = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               step_in  = S_T_V1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ma_in    = op_a;
            mb_in    = op_b;
            mcnt_in  = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            case (mcnt_ff)
               2'd0: begin pp0_in = prod; mcnt_in = 2'd1; end
               2'd1: begin cr_in = prod[31:0]; mcnt_in = 2'd2; end
               2'd2: begin cr_in = cr_ff + prod[31:0]; mcnt_in = 2'd3; end
               default: begin
                  mcnt_in  = 2'd0;
                  state_in = ST_LOAD;
                  case (step_ff)
                     S_T_V1:   begin v1_in = asr32(r32, 11); step_in = S_T_BB; end
                     S_T_BB:   begin bb_in = asr32(r32, 12); step_in = S_T_FINE; end
                     S_T_FINE: begin tfine_in = v1_ff + asr32(r32, 14); step_in = S_P_XX; end
                     S_P_XX:   begin xx_in = res; step_in = S_P_W2A; end
                     S_P_W2A:  begin w2_in = res; step_in = S_P_W2B; end
                     S_P_W2B:  begin
                        w2_in = w2_ff + (res << 17) + (p4 << 35); step_in = S_P_W1A;
                     end
                     S_P_W1A:  begin w1_in = asr64(res, 8); step_in = S_P_W1B; end
                     S_P_W1B:  begin
                        w1_in = w1_ff + (res << 12) + (64'd1 << 47); step_in = S_P_W1C;
                     end
                     S_P_W1C:  begin
                        w1_in   = w1_new;
                        step_in = S_P_NUM;
                        if (w1_new == 64'd0) begin
                           // zero divisor: no pressure, no humidity
                           ok_in    = 1'b0;
                           press_in = '0;
                           hum_in   = '0;
                           state_in = ST_OUT;
                        end
                     end
                     S_P_NUM:  begin
                        div_req.start = 1'b1;
                        div_req.num   = res;
                        div_req.den   = w1_ff;
                        state_in      = ST_DIV;
                     end
                     S_P_E1A:  begin tq_in = res; step_in = S_P_E1B; end
                     S_P_E1B:  begin e1_in = asr64(res, 25); step_in = S_P_E2; end
                     S_P_E2:   begin
                        ok_in = 1'b1;
                        if (pfin[63]) begin
                           press_in = '0;
                        end else if (pfin[63:32] != 32'd0) begin
                           press_in = 32'hffff_ffff;
                        end else begin
                           press_in = pfin[31:0];
                        end
                        hum_in  = '0;
                        step_in = S_H_U;
                        if (!calib.has_hum) begin
                           state_in = ST_OUT;
                        end
                     end
                     S_H_U:    begin
                        hu_in = asr32((32'(item_ff.adc_hum) << 14) - (h4 << 20) - r32
                                      + HUM_ROUND_A, 15);
                        step_in = S_H_A;
                     end
                     S_H_A:    begin ha_in = asr32(r32, 10); step_in = S_H_B; end
                     S_H_B:    begin hb_in = asr32(r32, 11) + HUM_ADD_B; step_in = S_H_W1; end
                     S_H_W1:   begin hw_in = asr32(r32, 10) + HUM_ADD_A; step_in = S_H_W2; end
                     S_H_W2:   begin hw_in = asr32(r32 + HUM_ROUND_B, 14); step_in = S_H_V; end
                     S_H_V:    begin hv_in = r32; step_in = S_H_M; end
                     S_H_M:    begin hm_in = asr32(r32, 7); step_in = S_H_FIN; end
                     S_H_FIN:  begin
                        if (hv_fin[31]) begin
                           hum_in = '0;
                        end else if (hv_fin > HUM_MAX_RAW) begin
                           hum_in = HUM_MAX_RAW[28:12];
                        end else begin
                           hum_in = hv_fin[28:12];
                        end
                        state_in = ST_OUT;
                     end
                     default:  begin state_in = ST_IDLE; end
                  endcase
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.quo;
               step_in  = S_P_E1A;
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, hum_ff, press_ff, temp_sat};
               rsp_user_in  = ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mcnt_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;   item_ff <= item_in;  ma_ff <= ma_in;  mb_ff <= mb_in;
      pp0_ff   <= pp0_in;    cr_ff   <= cr_in;
      v1_ff    <= v1_in;     bb_ff   <= bb_in;    tfine_ff <= tfine_in;
      xx_ff    <= xx_in;     w2_ff   <= w2_in;    w1_ff <= w1_in;  p_ff <= p_in;
      tq_ff    <= tq_in;     e1_ff   <= e1_in;
      hu_ff    <= hu_in;     ha_ff   <= ha_in;    hb_ff <= hb_in;  hw_ff <= hw_in;
      hv_ff    <= hv_in;     hm_ff   <= hm_in;
      press_ff <= press_in;  hum_ff  <= hum_in;   ok_ff <= ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "assert_macros.svh"
   `ASSERT_NEXT(a_div_enter, clock, reset, div_req.start, state_ff == ST_DIV)
   `ASSERT_IMPL(a_mcnt_rest, clock, reset, state_ff != ST_MUL, mcnt_ff == 2'd0)
   `ASSERT_IMPL(a_bad_zero, clock, reset, rsp_valid_ff && !rsp_user_ff, rsp_data_ff[64:16] == 49'd0)
   `ASSERT_IMPL(a_hum_max, clock, reset, rsp_valid_ff, rsp_data_ff[64:48] <= HUM_MAX_OUT)
endmodule

// File: hw/rtl/env_sensor_integer_compensation.sv
// top level of the sensor integer compensation block: calibration registers and wiring
// depends on esic_pkg, esic_front, esic_div, esic_back
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  tdata: adc_temp, adc_press, adc_hum
//   rsp_      out   rsp_tvalid/rsp_tready  tdata: temp, pressure, humidity; tuser: pressure_ok
//   csr_      in    csr_we                 csr_addr, csr_wdata
//
// from dequeue to result beat, one item runs 21 multiply steps on the one shared 32x32
// multiplier and a pass through the bit-serial 64-bit divider;
// without humidity the humidity steps are skipped
// a zero pressure divisor ends the item after the temperature and divisor steps
// reset is synchronous; it empties the queue, idles the sequencer and sets has_humidity
// a two-beat queue accepts requests until full while the back end works or its result waits
module env_sensor_integer_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // temperature_centi[15:0], pressure_q24_8[47:16],
                                    // humidity_q7_10[64:48], zero fill
   output logic        rsp_tuser,   // pressure_ok
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import esic_pkg::*;

   calib_type   calib_ff, calib_in;
   logic        q_valid, q_pop;
   item_type    q_item;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // calibration register writes, masked to each register's width
   always_comb begin
      calib_in = calib_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TEMP_CALIB: calib_in.temp     = csr_wdata[47:0];
            CSR_PRESS_LO:   calib_in.press_lo = csr_wdata;
            CSR_PRESS_HI:   calib_in.press_hi = csr_wdata;
            CSR_MIXED:      calib_in.mixed    = csr_wdata[47:0];
            CSR_HUM_CALIB:  calib_in.hum      = csr_wdata[39:0];
            CSR_HAS_HUM:    calib_in.has_hum  = csr_wdata[0];
            default:        calib_in = calib_ff;   // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '{has_hum: 1'b1, default: '0};
      end else begin
         calib_ff <= calib_in;
      end
   end

   // front: request queue
   esic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   // serial divider used by the pressure path
   esic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // back: compensation sequencer and result register
   esic_back u_back (
      .clock      (clock),
      .reset      (reset),
      .calib      (calib_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
